// ===== rtl/rational_arithmetic_unit_top_macros.svh =====
// Assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH

// same-cycle implication
`define RAU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rau_pkg.sv =====
// Shared types and codes for the rational arithmetic unit
package rau_pkg;

    localparam int DW = 64;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;
    localparam logic [2:0] OP_RED = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_INV  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam logic [1:0] CMP_EQ = 2'b00;
    localparam logic [1:0] CMP_GT = 2'b01;
    localparam logic [1:0] CMP_LT = 2'b11;

    localparam logic MODE_GCD = 1'b0;
    localparam logic MODE_DIV = 1'b1;

    typedef struct packed {
        logic start;
        logic mode;
    } t_unit_req;

endpackage

// ===== rtl/rau_iter_unit.sv =====
// Shared iterative unit: binary gcd or restoring 64-bit unsigned division
module rau_iter_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rau_pkg::t_unit_req          i_req,
    input  logic [rau_pkg::DW-1:0]      i_opa,
    input  logic [rau_pkg::DW-1:0]      i_opb,
    output logic                        o_done,
    output logic [rau_pkg::DW-1:0]      o_res
);
    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_GCD  = 2'd1;
    localparam logic [1:0] U_DIV  = 2'd2;

    logic [1:0]               r_state, n_state;
    logic                     r_done, n_done;
    logic [rau_pkg::DW-1:0]   r_u, n_u, r_v, n_v, r_r, n_r, r_res, n_res;
    logic [5:0]               r_k, n_k;
    logic [rau_pkg::DW:0]     w_duv, w_trial;
    logic [rau_pkg::DW-1:0]   w_dvu;

    assign w_duv   = {1'b0, r_u} - {1'b0, r_v};
    assign w_dvu   = r_v - r_u;
    assign w_trial = {r_r, r_u[rau_pkg::DW-1]} - {1'b0, r_v};

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_u     = r_u;
        n_v     = r_v;
        n_r     = r_r;
        n_k     = r_k;
        n_res   = r_res;
        unique case (r_state)
            U_IDLE: begin
                if (i_req.start) begin
                    n_u     = i_opa;
                    n_v     = i_opb;
                    n_r     = '0;
                    n_k     = '0;
                    n_state = (i_req.mode == rau_pkg::MODE_DIV) ? U_DIV : U_GCD;
                end
            end
            U_GCD: begin
                if (r_u == '0) begin
                    n_res   = r_v;
                    n_done  = 1'b1;
                    n_state = U_IDLE;
                end else if (r_v == '0) begin
                    n_res   = r_u;
                    n_done  = 1'b1;
                    n_state = U_IDLE;
                end else if (r_u == r_v) begin
                    n_res   = r_u << r_k;
                    n_done  = 1'b1;
                    n_state = U_IDLE;
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + 6'd1;
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (!w_duv[rau_pkg::DW]) begin
                    n_u = {1'b0, w_duv[rau_pkg::DW-1:1]};
                end else begin
                    n_v = {1'b0, w_dvu[rau_pkg::DW-1:1]};
                end
            end
            U_DIV: begin
                n_u = {r_u[rau_pkg::DW-2:0], ~w_trial[rau_pkg::DW]};
                n_r = w_trial[rau_pkg::DW] ? {r_r[rau_pkg::DW-2:0], r_u[rau_pkg::DW-1]}
                                           : w_trial[rau_pkg::DW-1:0];
                n_k = r_k + 6'd1;
                if (&r_k) begin
                    n_res   = n_u;
                    n_done  = 1'b1;
                    n_state = U_IDLE;
                end
            end
            default: n_state = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u   <= n_u;
        r_v   <= n_v;
        r_r   <= n_r;
        r_k   <= n_k;
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/rational_arithmetic_unit_top.sv =====
// Rational arithmetic unit top level: sequencer, shared multiplier, output register
//
//  Channel  Dir  tdata (low bit up)                      tuser
//  s        in   a_num, a_den, b_num, b_den (32b each)   req_type (3b)
//  m        out  res_num(64), res_den(64), cmp_result(2) status (2b)
//
// One transaction at a time; o_s_tready is low from accept until the result is
// handed to the output register. Invalid or equal-compare operands go from S_CHECK
// straight to S_DONE and the output register; add/subtract run a 32-bit gcd, a 64-bit
// gcd and four divisions one after another on the shared unit.
// Output register lets the next transaction enter while a result waits on i_m_tready.
// Synchronous active-low reset clears control only.
`include "rational_arithmetic_unit_top_macros.svh"

module rational_arithmetic_unit_top #(
    parameter int WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,  // a_num, a_den, b_num, b_den
    input  logic [2:0]   i_s_tuser,  // req_type
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [135:0] o_m_tdata,  // res_num, res_den, cmp_result, zero pad
    output logic [1:0]   o_m_tuser   // status
);
    localparam int MW = WIDTH + 1;
    localparam int DW = rau_pkg::DW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_G1    = 4'd2;
    localparam logic [3:0] S_DB    = 4'd3;
    localparam logic [3:0] S_DA    = 4'd4;
    localparam logic [3:0] S_M1    = 4'd5;
    localparam logic [3:0] S_M2    = 4'd6;
    localparam logic [3:0] S_M3    = 4'd7;
    localparam logic [3:0] S_MP    = 4'd8;
    localparam logic [3:0] S_MQ    = 4'd9;
    localparam logic [3:0] S_COMB  = 4'd10;
    localparam logic [3:0] S_G2    = 4'd11;
    localparam logic [3:0] S_DP    = 4'd12;
    localparam logic [3:0] S_DQ    = 4'd13;
    localparam logic [3:0] S_FIX   = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    logic [3:0]              r_state, n_state;
    logic                    r_launched, n_launched;
    logic                    r_ovalid, n_ovalid;
    logic [2:0]              r_op, n_op;
    logic signed [WIDTH-1:0] r_an, n_an, r_ad, n_ad, r_bn, n_bn, r_bd, n_bd;
    logic [DW-1:0]           r_g, n_g, r_ga, n_ga, r_gb, n_gb;
    logic signed [DW-1:0]    r_p, n_p, r_q, n_q, r_x, n_x, r_y, n_y;
    logic [DW-1:0]           r_rn, n_rn, r_rd, n_rd;
    logic [1:0]              r_st, n_st, r_cmp, n_cmp;
    logic [DW-1:0]           r_onum, n_onum, r_oden, n_oden;
    logic [1:0]              r_ost, n_ost, r_ocmp, n_ocmp;

    logic signed [DW-1:0]    w_an, w_ad, w_bn, w_bd;
    logic [DW-1:0]           w_mad, w_mbd, w_mp, w_mq;
    logic signed [MW-1:0]    w_ma, w_mb, w_gas, w_gbs;
    logic signed [2*MW-1:0]  w_prod;
    logic signed [DW-1:0]    w_prod64;
    logic [DW-1:0]           w_np, w_nq, w_np2, w_nq2;
    logic                    w_invalid, w_accept;
    rau_pkg::t_unit_req      w_req;
    logic [DW-1:0]           w_opa, w_opb, w_ures;
    logic                    w_udone, w_wait;

    assign w_an  = DW'(r_an);
    assign w_ad  = DW'(r_ad);
    assign w_bn  = DW'(r_bn);
    assign w_bd  = DW'(r_bd);
    assign w_mad = w_ad[DW-1] ? DW'(-w_ad) : DW'(w_ad);
    assign w_mbd = w_bd[DW-1] ? DW'(-w_bd) : DW'(w_bd);
    assign w_mp  = r_p[DW-1] ? DW'(-r_p) : DW'(r_p);
    assign w_mq  = r_q[DW-1] ? DW'(-r_q) : DW'(r_q);

    assign w_gas = $signed(r_ga[MW-1:0]);
    assign w_gbs = $signed(r_gb[MW-1:0]);

    assign w_invalid = (r_op > rau_pkg::OP_RED)
                    || ((r_op == rau_pkg::OP_RED) && (r_ad == '0))
                    || ((r_op < rau_pkg::OP_RED) && ((r_ad == '0) || (r_bd == '0)))
                    || ((r_op == rau_pkg::OP_DIV) && (r_bn == '0));

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        case (r_state)
            S_MP: begin
                w_ma = MW'(r_an);
                w_mb = (r_op == rau_pkg::OP_MUL) ? MW'(r_bn) : MW'(r_bd);
            end
            S_MQ: begin
                w_ma = MW'(r_ad);
                w_mb = (r_op == rau_pkg::OP_MUL) ? MW'(r_bd) : MW'(r_bn);
            end
            S_M1: begin
                w_ma = $signed(w_mad[MW-1:0]);
                w_mb = w_gbs;
            end
            S_M2: begin
                w_ma = r_ad[WIDTH-1] ? -w_gbs : w_gbs;
                w_mb = MW'(r_an);
            end
            S_M3: begin
                w_ma = r_bd[WIDTH-1] ? -w_gas : w_gas;
                w_mb = MW'(r_bn);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod   = w_ma * w_mb;
    assign w_prod64 = DW'(w_prod);

    always_comb begin
        case (r_state)
            S_G1:    begin w_opa = w_mad; w_opb = w_mbd; end
            S_DB:    begin w_opa = w_mbd; w_opb = r_g;   end
            S_DA:    begin w_opa = w_mad; w_opb = r_g;   end
            S_G2:    begin w_opa = w_mp;  w_opb = w_mq;  end
            S_DP:    begin w_opa = w_mp;  w_opb = r_g;   end
            S_DQ:    begin w_opa = w_mq;  w_opb = r_g;   end
            default: begin w_opa = '0;    w_opb = '0;    end
        endcase
    end

    assign w_wait = (r_state == S_G1) || (r_state == S_DB) || (r_state == S_DA)
                 || (r_state == S_G2) || (r_state == S_DP) || (r_state == S_DQ);
    assign w_req.start = w_wait && !r_launched;
    assign w_req.mode  = ((r_state == S_G1) || (r_state == S_G2)) ? rau_pkg::MODE_GCD
                                                                  : rau_pkg::MODE_DIV;

    rau_iter_unit u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_opa   (w_opa),
        .i_opb   (w_opb),
        .o_done  (w_udone),
        .o_res   (w_ures)
    );

    assign w_np  = r_p[DW-1] ? DW'(-r_x) : DW'(r_x);
    assign w_nq  = r_q[DW-1] ? DW'(-r_y) : DW'(r_y);
    assign w_np2 = w_nq[DW-1] ? DW'(-w_np) : w_np;
    assign w_nq2 = w_nq[DW-1] ? DW'(-w_nq) : w_nq;

    always_comb begin
        n_state    = r_state;
        n_launched = r_launched;
        n_op = r_op; n_an = r_an; n_ad = r_ad; n_bn = r_bn; n_bd = r_bd;
        n_g = r_g; n_ga = r_ga; n_gb = r_gb;
        n_p = r_p; n_q = r_q; n_x = r_x; n_y = r_y;
        n_rn = r_rn; n_rd = r_rd; n_st = r_st; n_cmp = r_cmp;
        n_ovalid = r_ovalid && !i_m_tready;
        n_onum = r_onum; n_oden = r_oden; n_ost = r_ost; n_ocmp = r_ocmp;

        if (w_req.start) n_launched = 1'b1;
        if (w_udone) n_launched = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = i_s_tuser;
                    n_an    = i_s_tdata[WIDTH-1:0];
                    n_ad    = i_s_tdata[32+WIDTH-1:32];
                    n_bn    = i_s_tdata[64+WIDTH-1:64];
                    n_bd    = i_s_tdata[96+WIDTH-1:96];
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_rn  = '0;
                n_rd  = '0;
                n_st  = rau_pkg::ST_OK;
                n_cmp = rau_pkg::CMP_EQ;
                if (w_invalid) begin
                    n_st    = rau_pkg::ST_INV;
                    n_state = S_DONE;
                end else if ((r_op == rau_pkg::OP_CMP) && (r_an == r_bn) && (r_ad == r_bd)) begin
                    n_state = S_DONE;
                end else if ((r_op == rau_pkg::OP_MUL) || (r_op == rau_pkg::OP_DIV)) begin
                    n_state = S_MP;
                end else if (r_op == rau_pkg::OP_RED) begin
                    n_p     = w_an;
                    n_q     = w_ad;
                    n_state = S_G2;
                end else begin
                    n_state = S_G1;
                end
            end
            S_G1:  if (w_udone) begin n_g  = w_ures; n_state = S_DB; end
            S_DB:  if (w_udone) begin n_gb = w_ures; n_state = S_DA; end
            S_DA:  if (w_udone) begin n_ga = w_ures; n_state = S_M1; end
            S_M1:  begin n_q = w_prod64; n_state = S_M2; end
            S_M2:  begin n_x = w_prod64; n_state = S_M3; end
            S_M3:  begin n_y = w_prod64; n_state = S_COMB; end
            S_MP:  begin n_p = w_prod64; n_state = S_MQ; end
            S_MQ:  begin n_q = w_prod64; n_state = S_G2; end
            S_COMB: begin
                if (r_op == rau_pkg::OP_CMP) begin
                    n_cmp   = (r_x > r_y) ? rau_pkg::CMP_GT : rau_pkg::CMP_LT;
                    n_state = S_DONE;
                end else begin
                    n_p     = (r_op == rau_pkg::OP_ADD) ? r_x + r_y : r_x - r_y;
                    n_state = S_G2;
                end
            end
            S_G2:  if (w_udone) begin n_g = w_ures; n_state = S_DP; end
            S_DP:  if (w_udone) begin n_x = w_ures; n_state = S_DQ; end
            S_DQ:  if (w_udone) begin n_y = w_ures; n_state = S_FIX; end
            S_FIX: begin
                if (w_np2 == '0) begin
                    n_rn = '0;
                    n_rd = DW'(1);
                    n_st = rau_pkg::ST_ZERO;
                end else begin
                    n_rn = w_np2;
                    n_rd = w_nq2;
                    n_st = rau_pkg::ST_OK;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_onum   = r_rn;
                    n_oden   = r_rd;
                    n_ost    = r_st;
                    n_ocmp   = r_cmp;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_launched <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_launched <= n_launched;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_an <= n_an; r_ad <= n_ad; r_bn <= n_bn; r_bd <= n_bd;
        r_g <= n_g; r_ga <= n_ga; r_gb <= n_gb;
        r_p <= n_p; r_q <= n_q; r_x <= n_x; r_y <= n_y;
        r_rn <= n_rn; r_rd <= n_rd; r_st <= n_st; r_cmp <= n_cmp;
        r_onum <= n_onum; r_oden <= n_oden; r_ost <= n_ost; r_ocmp <= n_ocmp;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {6'b0, r_ocmp, r_oden, r_onum};
    assign o_m_tuser  = r_ost;

    `RAU_ASSERT_NEXT(a_accept_to_check, w_accept, r_state == S_CHECK, "accept did not start check")
    `RAU_ASSERT_NOW(a_done_in_wait, w_udone, w_wait && r_launched, "unit done outside wait state")
    `RAU_ASSERT_NOW(a_zero_den_one, r_ovalid && (r_ost == rau_pkg::ST_ZERO),
        (r_onum == '0) && (r_oden == DW'(1)), "zero result not 0/1")
    `RAU_ASSERT_NOW(a_inv_zero, r_ovalid && (r_ost == rau_pkg::ST_INV),
        (r_onum == '0) && (r_oden == '0) && (r_ocmp == rau_pkg::CMP_EQ), "invalid fields nonzero")

endmodule

// ===== verif/rational_arithmetic_unit_top_checker.sv =====
// Checker for the rational arithmetic unit: predicts each result and compares it
`timescale 1ns / 100ps

module rational_arithmetic_unit_top_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [127:0] i_s_tdata,  // a_num, a_den, b_num, b_den
    input  logic [2:0]   i_s_tuser,  // req_type
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [135:0] i_m_tdata,  // res_num, res_den, cmp_result, zero pad
    input  logic [1:0]   i_m_tuser,  // status
    output int           o_errors,
    output int           o_pending
);

    typedef struct {
        logic [63:0] num;
        logic [63:0] den;
        logic [1:0]  status;
        logic [1:0]  cmp;
    } t_fraction_result;

    t_fraction_result result_q[$];

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? (64'd0 - longint'(unsigned'(v))) : v;
    endfunction

    function automatic longint unsigned euclid_gcd(longint unsigned a, longint unsigned b);
        longint unsigned t;
        if (a == 0) return b;
        if (b == 0) return a;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic longint signed_div(longint v, longint unsigned d);
        longint unsigned q;
        q = magnitude(v) / d;
        return (v < 0) ? longint'(64'd0 - q) : longint'(q);
    endfunction

    function automatic longint pos_lcm(longint a, longint b);
        longint g;
        longint l;
        g = longint'(euclid_gcd(magnitude(a), magnitude(b)));
        l = (a * b) / g;
        return (l < 0) ? -l : l;
    endfunction

    function automatic t_fraction_result predict_fraction(logic [2:0] op, logic [127:0] d);
        t_fraction_result r;
        longint an, ad, bn, bd, l, p, q, np, nq;
        longint unsigned g;
        an = longint'(signed'(d[31:0]));
        ad = longint'(signed'(d[63:32]));
        bn = longint'(signed'(d[95:64]));
        bd = longint'(signed'(d[127:96]));
        r = '{num: '0, den: '0, status: rau_pkg::ST_OK, cmp: rau_pkg::CMP_EQ};
        if (op > rau_pkg::OP_RED || (op == rau_pkg::OP_RED && ad == 0) ||
            (op < rau_pkg::OP_RED && (ad == 0 || bd == 0)) ||
            (op == rau_pkg::OP_DIV && bn == 0)) begin
            r.status = rau_pkg::ST_INV;
        end else if (op == rau_pkg::OP_CMP) begin
            if (!(an == bn && ad == bd)) begin
                l = pos_lcm(ad, bd);
                r.cmp = ((l / ad) * an > (l / bd) * bn) ? rau_pkg::CMP_GT : rau_pkg::CMP_LT;
            end
        end else begin
            case (op) inside
                rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                    l = pos_lcm(ad, bd);
                    p = (op == rau_pkg::OP_ADD) ? (l / ad) * an + (l / bd) * bn
                                                : (l / ad) * an - (l / bd) * bn;
                    q = l;
                end
                rau_pkg::OP_MUL: begin
                    p = an * bn;
                    q = ad * bd;
                end
                rau_pkg::OP_DIV: begin
                    p = an * bd;
                    q = ad * bn;
                end
                default: begin
                    p = an;
                    q = ad;
                end
            endcase
            g = euclid_gcd(magnitude(p), magnitude(q));
            if (g == 0) g = 1;
            np = signed_div(p, g);
            nq = signed_div(q, g);
            if (nq < 0) begin
                np = -np;
                nq = -nq;
            end
            r.num = np;
            r.den = nq;
            if (np == 0) begin
                r.status = rau_pkg::ST_ZERO;
                r.den = 64'd1;
            end
        end
        return r;
    endfunction

    assign o_pending = result_q.size();

    always @(posedge i_clk) begin
        t_fraction_result exp_r;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                result_q.push_back(predict_fraction(i_s_tuser, i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (result_q.size() == 0) begin
                    $error("result transaction with none expected");
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = result_q.pop_front();
                    if (i_m_tdata[63:0] !== exp_r.num ||
                        i_m_tdata[127:64] !== exp_r.den ||
                        i_m_tdata[129:128] !== exp_r.cmp ||
                        i_m_tuser !== exp_r.status)
                        o_errors <= o_errors + 1;
                    if (i_m_tdata[63:0] !== exp_r.num)
                        $error("res_num: expected %0d, got %0d",
                               $signed(exp_r.num), $signed(i_m_tdata[63:0]));
                    if (i_m_tdata[127:64] !== exp_r.den)
                        $error("res_den: expected %0d, got %0d",
                               $signed(exp_r.den), $signed(i_m_tdata[127:64]));
                    if (i_m_tdata[129:128] !== exp_r.cmp)
                        $error("cmp_result: expected %b, got %b",
                               exp_r.cmp, i_m_tdata[129:128]);
                    if (i_m_tuser !== exp_r.status)
                        $error("status: expected %0d, got %0d", exp_r.status, i_m_tuser);
                end
            end
        end
    end

endmodule

// ===== verif/rational_arithmetic_unit_top_test.sv =====
// Testbench top for the rational arithmetic unit: stimulus, idling and verdict
`timescale 1ns / 100ps

module rational_arithmetic_unit_top_test;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [2:0]   s_tuser = rau_pkg::OP_ADD;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic [1:0]   m_tuser;
    int           errors;
    int           pending;
    int           send_idle = 0;
    int           recv_stall = 0;
    int           hold_requests = 0;
    int           hold_served = 0;
    int           hold_left = 0;

    always #1 i_clk = ~i_clk;

    rational_arithmetic_unit_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser)
    );

    rational_arithmetic_unit_top_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_errors(errors), .o_pending(pending)
    );

    // result side: random stalls, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left <= 3000;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic send_op(logic [2:0] op, int an, int ad, int bn, int bd);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {bd, bn, ad, an};
        do @(posedge i_clk); while (!s_tready);
    endtask

    function automatic int rand_operand();
        int k;
        k = $urandom_range(99);
        if (k < 30) return int'($urandom_range(40)) - 20;
        if (k < 36) return 0;
        if (k < 46) begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return -1;
                default: return 1;
            endcase
        end
        if (k < 60) return int'($urandom_range(2000)) - 1000;
        return $urandom();
    endfunction

    task automatic send_random();
        logic [2:0] op;
        int an, ad, bn, bd;
        op = ($urandom_range(99) < 4) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
        an = rand_operand();
        ad = rand_operand();
        bn = rand_operand();
        bd = rand_operand();
        if ($urandom_range(99) < 10) begin
            bn = an;
            bd = ad;
        end
        send_op(op, an, ad, bn, bd);
    endtask

    initial begin
        #5_000_000;
        $display("** rational_arithmetic_unit_top: FAILED **");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_op(rau_pkg::OP_ADD, 1, 2, 1, 3);
        send_op(rau_pkg::OP_SUB, 1, 2, 1, 2);
        send_op(rau_pkg::OP_SUB, 1, 3, 1, 2);
        send_op(rau_pkg::OP_MUL, -2, 3, 3, -4);
        send_op(rau_pkg::OP_DIV, 2, 3, 4, 9);
        send_op(rau_pkg::OP_DIV, 2, 3, 0, 9);
        send_op(rau_pkg::OP_CMP, 1, 2, 1, 2);
        send_op(rau_pkg::OP_CMP, 2, 3, 1, 2);
        send_op(rau_pkg::OP_CMP, 1, 3, 1, 2);
        send_op(rau_pkg::OP_CMP, 2, 4, 1, 2);
        send_op(rau_pkg::OP_RED, 6, -8, 0, 0);
        send_op(rau_pkg::OP_RED, 5, 0, 1, 1);
        send_op(rau_pkg::OP_ADD, 1, 0, 1, 2);
        send_op(rau_pkg::OP_MUL, 1, 2, 1, 0);
        send_op(rau_pkg::OP_MUL, 0, 5, 7, 3);
        send_op(3'd6, 1, 2, 3, 4);
        send_op(3'd7, 1, 2, 3, 4);
        send_op(rau_pkg::OP_ADD, 32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_ffff, 32'h7fff_fffd);
        send_op(rau_pkg::OP_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1);
        send_op(rau_pkg::OP_MUL, 32'h8000_0000, -1, 32'h8000_0000, -1);
        send_op(rau_pkg::OP_DIV, 32'h8000_0000, 1, -1, 32'h8000_0000);
        send_op(rau_pkg::OP_RED, 32'h8000_0000, 32'h8000_0000, 0, 0);
        send_op(rau_pkg::OP_CMP, 32'h7fff_ffff, 1, 32'h8000_0000, 1);
        send_op(rau_pkg::OP_RED, -1, -1, 0, 0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 87; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 87; end
                default: begin send_idle = 22; recv_stall = 22; end
            endcase
            for (int n = 0; n < 250; n++) begin
                if (ph == 0 && n == 100) hold_requests <= hold_requests + 1;
                if (ph == 1 && n == 125) begin
                    s_tvalid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
                send_random();
            end
        end
        s_tvalid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (errors == 0)
            $display("** rational_arithmetic_unit_top: PASSED **");
        else
            $display("** rational_arithmetic_unit_top: FAILED **");
        $finish;
    end

endmodule
